// File: design/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants for the light scissor rectangle core
// Fixed-point format, pipeline depths, register map and side-band structs.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  // slope magnitudes are below 2^62
  localparam int unsigned MAG_W       = 62;
  // one root bit per stage over a 64-bit radicand
  localparam int unsigned SQRT_STAGES = 32;
  // one quotient bit per stage
  localparam int unsigned DIV_STAGES  = MAG_W;
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned NSLOPE      = 4;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_PROJ_X_SCALE  = 2'd2,
    REG_PROJ_Y_SCALE  = 2'd3
  } reg_idx_e;

  // data that rides alongside the square root pipeline
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        r;
    logic               okx;
    logic               oky;
  } sq_side_t;

  // data that rides alongside the divider pipeline
  typedef struct packed {
    logic [NSLOPE-1:0] neg;
    logic [NSLOPE-1:0] sat;
    logic              okx;
    logic              oky;
  } dv_side_t;

  // signed product divided by four, truncating toward zero
  function automatic logic signed [61:0] div4(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd3 : 64'sd0);
    return t[63:2];
  endfunction

endpackage

// File: design/slr_isqrt.sv
// ----------------------------------------------------------------------------
// slr_isqrt: pipelined integer square root
// Floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module slr_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  logic [32:0] rem_q  [slr_pkg::SQRT_STAGES];
  logic [32:0] rem_d  [slr_pkg::SQRT_STAGES];
  logic [31:0] root_q [slr_pkg::SQRT_STAGES];
  logic [31:0] root_d [slr_pkg::SQRT_STAGES];
  logic [63:0] rad_q  [slr_pkg::SQRT_STAGES];
  logic [63:0] rad_d  [slr_pkg::SQRT_STAGES];

  always_comb begin
    for (int k = 0; k < slr_pkg::SQRT_STAGES; k++) begin
      logic [32:0] rem_in;
      logic [31:0] root_in;
      logic [63:0] rad_in;
      logic [34:0] rem_sh;
      logic [34:0] trial;
      rem_in  = (k == 0) ? 33'd0 : rem_q[(k == 0) ? 0 : k - 1];
      root_in = (k == 0) ? 32'd0 : root_q[(k == 0) ? 0 : k - 1];
      rad_in  = (k == 0) ? rad_i : rad_q[(k == 0) ? 0 : k - 1];
      rem_sh  = {rem_in, rad_in[63:62]};
      trial   = {1'b0, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d[k]  = 33'(rem_sh - trial);
        root_d[k] = {root_in[30:0], 1'b1};
      end else begin
        rem_d[k]  = rem_sh[32:0];
        root_d[k] = {root_in[30:0], 1'b0};
      end
      rad_d[k] = {rad_in[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < slr_pkg::SQRT_STAGES; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
    end
  end

  assign root_o = root_q[slr_pkg::SQRT_STAGES-1];

endmodule

// File: design/slr_div.sv
// ----------------------------------------------------------------------------
// slr_div: pipelined fractional divider
// floor(num * 2^FRAC_BITS / den), one quotient bit per stage. Valid when
// the quotient is below 2^MAG_W; larger cases are flagged upstream.
// ----------------------------------------------------------------------------
module slr_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [slr_pkg::MAG_W-1:0] num_i,
  input  logic [slr_pkg::MAG_W-1:0] den_i,
  output logic [slr_pkg::MAG_W-1:0] quo_o
);

  localparam int unsigned W  = slr_pkg::MAG_W;
  localparam int unsigned HI = W - slr_pkg::FRAC_BITS;

  logic [W-1:0] rem_q [slr_pkg::DIV_STAGES];
  logic [W-1:0] rem_d [slr_pkg::DIV_STAGES];
  logic [W-1:0] dvd_q [slr_pkg::DIV_STAGES];
  logic [W-1:0] dvd_d [slr_pkg::DIV_STAGES];
  logic [W-1:0] den_q [slr_pkg::DIV_STAGES];
  logic [W-1:0] den_d [slr_pkg::DIV_STAGES];
  logic [W-1:0] quo_q [slr_pkg::DIV_STAGES];
  logic [W-1:0] quo_d [slr_pkg::DIV_STAGES];

  always_comb begin
    for (int k = 0; k < slr_pkg::DIV_STAGES; k++) begin
      logic [W-1:0] rem_in;
      logic [W-1:0] dvd_in;
      logic [W-1:0] den_in;
      logic [W-1:0] quo_in;
      logic [W:0]   rem_sh;
      // the upper numerator bits seed the remainder, the rest shift in
      rem_in = (k == 0) ? W'(num_i[W-1:HI]) : rem_q[(k == 0) ? 0 : k - 1];
      dvd_in = (k == 0) ? {num_i[HI-1:0], {slr_pkg::FRAC_BITS{1'b0}}}
                        : dvd_q[(k == 0) ? 0 : k - 1];
      den_in = (k == 0) ? den_i : den_q[(k == 0) ? 0 : k - 1];
      quo_in = (k == 0) ? '0 : quo_q[(k == 0) ? 0 : k - 1];
      rem_sh = {rem_in, dvd_in[W-1]};
      if (rem_sh >= {1'b0, den_in}) begin
        rem_d[k] = W'(rem_sh - {1'b0, den_in});
        quo_d[k] = {quo_in[W-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_sh[W-1:0];
        quo_d[k] = {quo_in[W-2:0], 1'b0};
      end
      dvd_d[k] = {dvd_in[W-2:0], 1'b0};
      den_d[k] = den_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < slr_pkg::DIV_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        dvd_q[k] <= dvd_d[k];
        den_q[k] <= den_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[slr_pkg::DIV_STAGES-1];

endmodule

// File: design/sphere_light_scissor_rect_core.sv
// ----------------------------------------------------------------------------
// sphere_light_scissor_rect_core: point light scissor rectangle
// Tangent-plane solve per axis in Q16.16, projected to clamped pixel edges.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transfer per light; tdata holds light_x, light_y,
//   light_z (signed Q16.16) and light_radius (unsigned Q15.16).
//   Output stream: one transfer per light with the left, right, top and
//   bottom scissor edges in pixels, clamped to the screen.
//   APB port: screen size and perspective scales; write them only while
//   no light is in flight.
//   Pipeline: 104 register stages (4 setup stages, 32 square root
//   stages, 3 stages of products and sums, 62 divider stages, 2
//   projection stages and the output register).
//   Throughput: one light per cycle unless the output stalls; the
//   square root and the four slope dividers are fully pipelined, one
//   bit per stage.
//   Reset: pipeline valid bits clear, registers take 1280x720 and unit
//   scales.
//   Stall: when the output holds a result that is not taken, the whole
//   pipeline holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sphere_light_scissor_rect_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // light_x[31:0], light_y[63:32], light_z[95:64], light_radius[126:96]
  input  logic [127:0]                s_axis_tdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // left_edge[13:0], right_edge[27:14], top_edge[41:28], bottom_edge[55:42]
  output logic [55:0]                 m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // ---------------------------------------------------------------- config
  logic [13:0] width_q, height_q;
  logic [30:0] xscale_q, yscale_q;
  slr_pkg::reg_idx_e reg_sel;

  assign reg_sel = slr_pkg::reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 14'd1280;
      height_q <= 14'd720;
      xscale_q <= 31'd65536;
      yscale_q <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        slr_pkg::REG_SCREEN_WIDTH:  width_q  <= pwdata[13:0];
        slr_pkg::REG_SCREEN_HEIGHT: height_q <= pwdata[13:0];
        slr_pkg::REG_PROJ_X_SCALE:  xscale_q <= pwdata[30:0];
        slr_pkg::REG_PROJ_Y_SCALE:  yscale_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      slr_pkg::REG_SCREEN_WIDTH:  prdata = {18'd0, width_q};
      slr_pkg::REG_SCREEN_HEIGHT: prdata = {18'd0, height_q};
      slr_pkg::REG_PROJ_X_SCALE:  prdata = {1'b0, xscale_q};
      slr_pkg::REG_PROJ_Y_SCALE:  prdata = {1'b0, yscale_q};
      default:                    prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ pipe control
  // Advance every stage together unless a result waits at the output.
  logic out_v_q;
  logic pipe_en;

  assign pipe_en       = !out_v_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // ---------------------------------------------------- stage A: input regs
  logic               a_v_q;
  logic signed [31:0] a_x_q, a_y_q, a_z_q;
  logic [30:0]        a_r_q;

  // ------------------------------------------------------- stage B: squares
  logic               b_v_q;
  logic signed [31:0] b_x_q, b_y_q, b_z_q;
  logic [30:0]        b_r_q;
  logic [63:0]        b_cx2_q, b_cy2_q, b_z2_q, b_r2_q;
  logic [31:0]        ax_abs, ay_abs, az_abs;

  assign ax_abs = a_x_q[31] ? 32'(-a_x_q) : a_x_q;
  assign ay_abs = a_y_q[31] ? 32'(-a_y_q) : a_y_q;
  assign az_abs = a_z_q[31] ? 32'(-a_z_q) : a_z_q;

  // --------------------------------------------- stage C: squared distances
  logic               c_v_q;
  logic signed [31:0] c_x_q, c_y_q, c_z_q;
  logic [30:0]        c_r_q;
  logic [63:0]        c_l2x_q, c_l2y_q, c_r2_q;

  // ------------------------------------------ stage D: radicands and checks
  logic              d_v_q;
  slr_pkg::sq_side_t d_side_q;
  logic [63:0]       d_radx_q, d_rady_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (pipe_en) begin
      a_v_q <= s_axis_tvalid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_x_q   <= s_axis_tdata[31:0];
      a_y_q   <= s_axis_tdata[63:32];
      a_z_q   <= s_axis_tdata[95:64];
      a_r_q   <= s_axis_tdata[126:96];

      b_x_q   <= a_x_q;
      b_y_q   <= a_y_q;
      b_z_q   <= a_z_q;
      b_r_q   <= a_r_q;
      b_cx2_q <= ax_abs * ax_abs;
      b_cy2_q <= ay_abs * ay_abs;
      b_z2_q  <= az_abs * az_abs;
      b_r2_q  <= {1'b0, a_r_q} * {1'b0, a_r_q};

      c_x_q   <= b_x_q;
      c_y_q   <= b_y_q;
      c_z_q   <= b_z_q;
      c_r_q   <= b_r_q;
      c_l2x_q <= b_cx2_q + b_z2_q;
      c_l2y_q <= b_cy2_q + b_z2_q;
      c_r2_q  <= b_r2_q;

      // drop an axis when the centre is not in front or its distance in that axis plane does not exceed the radius
      d_side_q.x   <= c_x_q;
      d_side_q.y   <= c_y_q;
      d_side_q.z   <= c_z_q;
      d_side_q.r   <= c_r_q;
      d_side_q.okx <= !c_z_q[31] && (c_z_q != 32'sd0) && (c_l2x_q > c_r2_q);
      d_side_q.oky <= !c_z_q[31] && (c_z_q != 32'sd0) && (c_l2y_q > c_r2_q);
      d_radx_q     <= c_l2x_q - c_r2_q;
      d_rady_q     <= c_l2y_q - c_r2_q;
    end
  end

  // ---------------------------------------------------------- square roots
  logic [31:0]       s_rootx, s_rooty;
  slr_pkg::sq_side_t sq_dly_q [slr_pkg::SQRT_STAGES];
  logic [slr_pkg::SQRT_STAGES-1:0] sq_v_q;

  slr_isqrt u_sqrt_x (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .rad_i  (d_radx_q),
    .root_o (s_rootx)
  );

  slr_isqrt u_sqrt_y (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .rad_i  (d_rady_q),
    .root_o (s_rooty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= '0;
    end else if (pipe_en) begin
      sq_v_q <= {sq_v_q[slr_pkg::SQRT_STAGES-2:0], d_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sq_dly_q[0] <= d_side_q;
      for (int k = 1; k < slr_pkg::SQRT_STAGES; k++) begin
        sq_dly_q[k] <= sq_dly_q[k-1];
      end
    end
  end

  // ------------------------------------------------------ stage E: products
  slr_pkg::sq_side_t sq_out;
  logic signed [32:0] ex, ey, ez, er, esx, esy;
  logic signed [65:0] p_csx, p_zsx, p_rcx, p_csy, p_zsy, p_rcy, p_rz;

  assign sq_out = sq_dly_q[slr_pkg::SQRT_STAGES-1];
  assign ex     = {sq_out.x[31], sq_out.x};
  assign ey     = {sq_out.y[31], sq_out.y};
  assign ez     = {sq_out.z[31], sq_out.z};
  assign er     = {2'b00, sq_out.r};
  assign esx    = {1'b0, s_rootx};
  assign esy    = {1'b0, s_rooty};
  assign p_csx  = ex * esx;
  assign p_zsx  = ez * esx;
  assign p_rcx  = er * ex;
  assign p_csy  = ey * esy;
  assign p_zsy  = ez * esy;
  assign p_rcy  = er * ey;
  assign p_rz   = er * ez;

  logic               e_v_q, e_okx_q, e_oky_q;
  logic signed [63:0] e_csx_q, e_zsx_q, e_rcx_q, e_csy_q, e_zsy_q, e_rcy_q, e_rz_q;

  // ------------------------------------------------ stage F: slope numerators
  logic               f_v_q, f_okx_q, f_oky_q;
  logic signed [62:0] f_n1x_q, f_d1x_q, f_n2x_q, f_d2x_q;
  logic signed [62:0] f_n1y_q, f_d1y_q, f_n2y_q, f_d2y_q;
  logic signed [61:0] q_csx, q_zsx, q_rcx, q_csy, q_zsy, q_rcy, q_rz;

  assign q_csx = slr_pkg::div4(e_csx_q);
  assign q_zsx = slr_pkg::div4(e_zsx_q);
  assign q_rcx = slr_pkg::div4(e_rcx_q);
  assign q_csy = slr_pkg::div4(e_csy_q);
  assign q_zsy = slr_pkg::div4(e_zsy_q);
  assign q_rcy = slr_pkg::div4(e_rcy_q);
  assign q_rz  = slr_pkg::div4(e_rz_q);

  // -------------------------------------------- stage G: divider operands
  logic               g_v_q, g_okx_q, g_oky_q;
  logic [slr_pkg::MAG_W-1:0] g_mag_q [slr_pkg::NSLOPE];
  logic [slr_pkg::MAG_W-1:0] g_den_q [slr_pkg::NSLOPE];
  logic [slr_pkg::NSLOPE-1:0] g_neg_q, g_sat_q;
  logic signed [62:0] f_num [slr_pkg::NSLOPE];
  logic signed [62:0] f_den [slr_pkg::NSLOPE];
  logic [slr_pkg::MAG_W-1:0] f_mag [slr_pkg::NSLOPE];
  logic [slr_pkg::NSLOPE-1:0] f_dpos;

  // slope order: t1 of x, t2 of x, t1 of y, t2 of y
  assign f_num[0] = f_n1x_q;
  assign f_num[1] = f_n2x_q;
  assign f_num[2] = f_n1y_q;
  assign f_num[3] = f_n2y_q;
  assign f_den[0] = f_d1x_q;
  assign f_den[1] = f_d2x_q;
  assign f_den[2] = f_d1y_q;
  assign f_den[3] = f_d2y_q;

  always_comb begin
    for (int i = 0; i < slr_pkg::NSLOPE; i++) begin
      f_mag[i]  = f_num[i][62] ? slr_pkg::MAG_W'(-f_num[i])
                               : f_num[i][slr_pkg::MAG_W-1:0];
      f_dpos[i] = !f_den[i][62] && (f_den[i] != 63'sd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
    end else if (pipe_en) begin
      e_v_q <= sq_v_q[slr_pkg::SQRT_STAGES-1];
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      e_okx_q <= sq_out.okx;
      e_oky_q <= sq_out.oky;
      e_csx_q <= p_csx[63:0];
      e_zsx_q <= p_zsx[63:0];
      e_rcx_q <= p_rcx[63:0];
      e_csy_q <= p_csy[63:0];
      e_zsy_q <= p_zsy[63:0];
      e_rcy_q <= p_rcy[63:0];
      e_rz_q  <= p_rz[63:0];

      f_okx_q <= e_okx_q;
      f_oky_q <= e_oky_q;
      f_n1x_q <= 63'(q_csx) - 63'(q_rz);
      f_d1x_q <= 63'(q_rcx) + 63'(q_zsx);
      f_n2x_q <= 63'(q_csx) + 63'(q_rz);
      f_d2x_q <= 63'(q_zsx) - 63'(q_rcx);
      f_n1y_q <= 63'(q_csy) - 63'(q_rz);
      f_d1y_q <= 63'(q_rcy) + 63'(q_zsy);
      f_n2y_q <= 63'(q_csy) + 63'(q_rz);
      f_d2y_q <= 63'(q_zsy) - 63'(q_rcy);

      // an axis needs both touch points in front of the eye
      g_okx_q <= f_okx_q && f_dpos[0] && f_dpos[1];
      g_oky_q <= f_oky_q && f_dpos[2] && f_dpos[3];
      for (int i = 0; i < slr_pkg::NSLOPE; i++) begin
        g_mag_q[i] <= f_mag[i];
        g_den_q[i] <= f_den[i][slr_pkg::MAG_W-1:0];
        g_neg_q[i] <= f_num[i][62];
        // quotient would reach 2^62: saturate
        g_sat_q[i] <= slr_pkg::MAG_W'(f_mag[i][slr_pkg::MAG_W-1:
                       slr_pkg::MAG_W-slr_pkg::FRAC_BITS]) >= f_den[i][slr_pkg::MAG_W-1:0];
      end
    end
  end

  // --------------------------------------------------------- slope dividers
  logic [slr_pkg::MAG_W-1:0] dv_quo [slr_pkg::NSLOPE];
  slr_pkg::dv_side_t dv_dly_q [slr_pkg::DIV_STAGES];
  slr_pkg::dv_side_t g_side;
  logic [slr_pkg::DIV_STAGES-1:0] dv_v_q;

  for (genvar i = 0; i < slr_pkg::NSLOPE; i++) begin : g_div
    slr_div u_div (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .num_i (g_mag_q[i]),
      .den_i (g_den_q[i]),
      .quo_o (dv_quo[i])
    );
  end

  assign g_side.neg = g_neg_q;
  assign g_side.sat = g_sat_q;
  assign g_side.okx = g_okx_q;
  assign g_side.oky = g_oky_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q <= '0;
    end else if (pipe_en) begin
      dv_v_q <= {dv_v_q[slr_pkg::DIV_STAGES-2:0], g_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dv_dly_q[0] <= g_side;
      for (int k = 1; k < slr_pkg::DIV_STAGES; k++) begin
        dv_dly_q[k] <= dv_dly_q[k-1];
      end
    end
  end

  // ------------------------------------------- stage H: scale times slope
  // Edge order: left, right, top, bottom. Top and bottom take the y slopes
  // swapped and negated to flip the vertical axis.
  slr_pkg::dv_side_t dv_out;
  logic [62:0] h_m    [slr_pkg::NSLOPE];
  logic [62:0] h_prod [slr_pkg::NSLOPE];
  logic [30:0] h_k    [slr_pkg::NSLOPE];
  logic [slr_pkg::NSLOPE-1:0] h_neg, h_sat;

  assign dv_out = dv_dly_q[slr_pkg::DIV_STAGES-1];

  always_comb begin
    for (int e = 0; e < slr_pkg::NSLOPE; e++) begin
      int src;
      src      = (e == 0) ? 0 : (e == 1) ? 1 : (e == 2) ? 3 : 2;
      h_m[e]   = dv_out.sat[src] ? (63'd1 << slr_pkg::MAG_W)
                                 : {1'b0, dv_quo[src]};
      h_neg[e] = (e < 2) ? dv_out.neg[src] : !dv_out.neg[src];
      h_k[e]   = (e < 2) ? xscale_q : yscale_q;
      h_prod[e] = 63'(h_k[e]) * 63'(h_m[e][31:0]);
      // product at or past one: the edge pins to the screen border
      h_sat[e] = (h_k[e] != 31'd0) && (h_m[e] != 63'd0) &&
                 ((h_m[e][62:32] != 31'd0) || (h_prod[e][62:32] != 31'd0));
    end
  end

  logic        h_v_q, h_okx_q, h_oky_q;
  logic [31:0] h_q_q [slr_pkg::NSLOPE];
  logic [slr_pkg::NSLOPE-1:0] h_neg_q, h_sat_q;

  // ------------------------------------------------ stage I: times screen size
  logic        i_v_q, i_okx_q, i_oky_q;
  logic [46:0] i_prod_q [slr_pkg::NSLOPE];
  logic [slr_pkg::NSLOPE-1:0] i_neg_q, i_sat_q;
  logic [32:0] i_num [slr_pkg::NSLOPE];

  always_comb begin
    for (int e = 0; e < slr_pkg::NSLOPE; e++) begin
      i_num[e] = h_neg_q[e] ? (33'h1_0000_0000 - {1'b0, h_q_q[e]})
                            : (33'h1_0000_0000 + {1'b0, h_q_q[e]});
    end
  end

  // ---------------------------------------------------- stage J: output reg
  logic [13:0] j_size [slr_pkg::NSLOPE];
  logic [13:0] j_edge [slr_pkg::NSLOPE];
  logic [13:0] out_edge_q [slr_pkg::NSLOPE];

  assign j_size[0] = width_q;
  assign j_size[1] = width_q;
  assign j_size[2] = height_q;
  assign j_size[3] = height_q;

  always_comb begin
    for (int e = 0; e < slr_pkg::NSLOPE; e++) begin
      logic ok;
      ok = (e < 2) ? i_okx_q : i_oky_q;
      if (!ok) begin
        // full-screen bounds: left and top at 0, right and bottom at size
        j_edge[e] = (e == 1 || e == 3) ? j_size[e] : 14'd0;
      end else if (i_sat_q[e]) begin
        j_edge[e] = i_neg_q[e] ? 14'd0 : j_size[e];
      end else begin
        j_edge[e] = i_prod_q[e][46:33];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q   <= 1'b0;
      i_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (pipe_en) begin
      h_v_q   <= dv_v_q[slr_pkg::DIV_STAGES-1];
      i_v_q   <= h_v_q;
      out_v_q <= i_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      h_okx_q <= dv_out.okx;
      h_oky_q <= dv_out.oky;
      h_neg_q <= h_neg;
      h_sat_q <= h_sat;
      i_okx_q <= h_okx_q;
      i_oky_q <= h_oky_q;
      i_neg_q <= h_neg_q;
      i_sat_q <= h_sat_q;
      for (int e = 0; e < slr_pkg::NSLOPE; e++) begin
        h_q_q[e]      <= h_prod[e][31:0];
        i_prod_q[e]   <= 47'(i_num[e]) * 47'(j_size[e]);
        out_edge_q[e] <= j_edge[e];
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_edge_q[3], out_edge_q[2], out_edge_q[1], out_edge_q[0]};

`ifndef SYNTHESIS
  a_x_edges_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_edge_q[0] <= width_q) && (out_edge_q[1] <= width_q))
    else $error("horizontal edge beyond screen width");

  a_y_edges_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_edge_q[2] <= height_q) && (out_edge_q[3] <= height_q))
    else $error("vertical edge beyond screen height");

  a_stall_holds_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(sq_v_q))
    else $error("square root stage moved during stall");

  a_stall_holds_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(dv_v_q))
    else $error("divider stage moved during stall");
`endif

endmodule
